@@ rtl/smi_pkg.sv @@
// Shared definitions for the small matrix inverse unit.
// Holds parameter defaults, order codes, cofactor index tables and the sideband type.
// No dependencies.
`default_nettype none

package smi_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_ELEMS      = 9;

    localparam logic [1:0] ORDER_2 = 2'd2;
    localparam logic [1:0] ORDER_3 = 2'd3;

    // elements that carry a result for an order 2 matrix (row-major bit index)
    localparam logic [NUM_ELEMS-1:0] ORDER2_USED = 9'b000011011;

    // next and second-next row/column, wrapping over three
    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    typedef struct packed {
        logic                 singular;
        logic [NUM_ELEMS-1:0] kill;
        logic [NUM_ELEMS-1:0] neg;
    } smi_side_t;

endpackage

`default_nettype wire

@@ rtl/small_matrix_inverse_unit.sv @@
// Small matrix inverse unit: adjugate over determinant, signed fixed point.
// Depends on smi_pkg and smi_div.
//
// Usage:
//   Matrix channel: mat_valid/mat_stall with matrix_order and nine row-major elements.
//   A transfer happens when mat_valid is high and mat_stall is low.
//   Inverse channel: inv_valid/inv_stall with nine inverse elements and singular.
//   Order 2 uses the top-left 2x2; unused outputs are zero. A zero determinant
//   raises singular and zeroes every element. Orders 0 and 1 give zeros, singular low.
//   The result passes through registered stages for products, cofactors and
//   determinant, then the quotient divider (one bit per stage), then saturation
//   into the output register. Throughput is one matrix per cycle while no
//   result is held by inv_stall; every stage is a register stage.
//   When inv_stall is high with a result waiting, the whole pipeline holds and
//   mat_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; data registers are not reset.
//   Quotients truncate toward zero and saturate to the signed output range.
`default_nettype none

module small_matrix_inverse_unit #(
    parameter int DATA_WIDTH = smi_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = smi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         mat_valid,
    output logic                              mat_stall,
    input  wire logic [1:0]                   matrix_order,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r0c0,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r0c1,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r0c2,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r1c0,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r1c1,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r1c2,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r2c0,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r2c1,
    input  wire logic signed [DATA_WIDTH-1:0] elem_r2c2,
    output logic                              inv_valid,
    input  wire logic                         inv_stall,
    output logic signed [DATA_WIDTH-1:0]      inv_r0c0,
    output logic signed [DATA_WIDTH-1:0]      inv_r0c1,
    output logic signed [DATA_WIDTH-1:0]      inv_r0c2,
    output logic signed [DATA_WIDTH-1:0]      inv_r1c0,
    output logic signed [DATA_WIDTH-1:0]      inv_r1c1,
    output logic signed [DATA_WIDTH-1:0]      inv_r1c2,
    output logic signed [DATA_WIDTH-1:0]      inv_r2c0,
    output logic signed [DATA_WIDTH-1:0]      inv_r2c1,
    output logic signed [DATA_WIDTH-1:0]      inv_r2c2,
    output logic                              singular
);

    import smi_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W;          // element product
    localparam int CW  = 2 * W + 1;      // cofactor
    localparam int PPW = 2 * W + 1;      // element times cofactor slice
    localparam int TMW = 3 * W + 2;      // element times cofactor
    localparam int DW  = 3 * W + 3;      // determinant
    localparam int NW  = CW + 2 * FRAC_BITS;
    localparam int LAT = W + 8;

    logic [LAT-1:0] vld_reg;
    logic           adv;

    logic signed [W-1:0] ein [NUM_ELEMS];

    logic [1:0]          ord1_reg, ord2_reg, ord3_reg, ord4_reg, ord5_reg;
    logic signed [W-1:0] a1_reg [NUM_ELEMS];
    logic signed [W-1:0] a2_reg [NUM_ELEMS];
    logic signed [W-1:0] a3_reg [NUM_ELEMS];
    logic signed [W-1:0] a4_reg [NUM_ELEMS];
    logic signed [PW-1:0] p1_reg [NUM_ELEMS];
    logic signed [PW-1:0] p2_reg [NUM_ELEMS];
    logic signed [CW-1:0] cof2_reg [NUM_ELEMS];
    logic signed [CW-1:0] cof3_reg [NUM_ELEMS];
    logic signed [CW-1:0] cof4_reg [NUM_ELEMS];
    logic signed [PPW-1:0] pl_reg [3];
    logic signed [PPW-1:0] ph_reg [3];
    logic signed [TMW-1:0] term_reg [3];
    logic signed [DW-1:0]  det5_reg;
    logic signed [CW-1:0]  num5_reg [NUM_ELEMS];
    logic                  ok5_reg;
    logic [DW-1:0]         dmag6_reg;
    logic [CW-1:0]         nmag6_reg [NUM_ELEMS];
    logic [CW-1:0]         nmag_next [NUM_ELEMS];
    smi_side_t             side6_next;
    smi_side_t             side_reg [W+2];

    logic signed [DW-1:0]  det3;
    logic signed [DW-1:0]  det5_next;
    logic signed [CW-1:0]  num5_next [NUM_ELEMS];
    logic                  det_zero;

    logic [W-1:0]          quo [NUM_ELEMS];
    logic                  ovf [NUM_ELEMS];
    logic signed [W-1:0]   inv_reg  [NUM_ELEMS];
    logic signed [W-1:0]   inv_next [NUM_ELEMS];
    logic                  singular_reg;

    assign ein[0] = elem_r0c0;
    assign ein[1] = elem_r0c1;
    assign ein[2] = elem_r0c2;
    assign ein[3] = elem_r1c0;
    assign ein[4] = elem_r1c1;
    assign ein[5] = elem_r1c2;
    assign ein[6] = elem_r2c0;
    assign ein[7] = elem_r2c1;
    assign ein[8] = elem_r2c2;

    // hold every stage while a finished result waits
    assign adv       = !(vld_reg[LAT-1] && inv_stall);
    assign mat_stall = vld_reg[LAT-1] && inv_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], mat_valid};
        end
    end

    // stages 1 to 4: minor products, cofactors, determinant partial products, terms
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ord1_reg <= matrix_order;
            ord2_reg <= ord1_reg;
            ord3_reg <= ord2_reg;
            ord4_reg <= ord3_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    p1_reg[r*3+c] <= PW'(ein[NXT1[r]*3+NXT1[c]]) * PW'(ein[NXT2[r]*3+NXT2[c]]);
                    p2_reg[r*3+c] <= PW'(ein[NXT1[r]*3+NXT2[c]]) * PW'(ein[NXT2[r]*3+NXT1[c]]);
                    // transpose while forming the adjugate
                    cof2_reg[c*3+r] <= CW'(p1_reg[r*3+c]) - CW'(p2_reg[r*3+c]);
                end
            end
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                a1_reg[k]   <= ein[k];
                a2_reg[k]   <= a1_reg[k];
                a3_reg[k]   <= a2_reg[k];
                a4_reg[k]   <= a3_reg[k];
                cof3_reg[k] <= cof2_reg[k];
                cof4_reg[k] <= cof3_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                pl_reg[j] <= PPW'(a2_reg[j]) * PPW'($signed({1'b0, cof2_reg[j*3][W-1:0]}));
                ph_reg[j] <= PPW'(a2_reg[j]) * PPW'($signed(cof2_reg[j*3][CW-1:W]));
                term_reg[j] <= (TMW'(ph_reg[j]) <<< W) + TMW'(pl_reg[j]);
            end
        end
    end

    // stage 5: determinant sum and selection by order
    always_comb
    begin
        det3 = DW'(term_reg[0]) + DW'(term_reg[1]) + DW'(term_reg[2]);
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            num5_next[k] = '0;
        end
        case (ord4_reg)
            ORDER_2:
            begin
                det5_next    = DW'(cof4_reg[8]);
                num5_next[0] = CW'(a4_reg[4]);
                num5_next[1] = -CW'(a4_reg[1]);
                num5_next[3] = -CW'(a4_reg[3]);
                num5_next[4] = CW'(a4_reg[0]);
            end
            ORDER_3:
            begin
                det5_next = det3;
                for (int k = 0; k < NUM_ELEMS; k++)
                begin
                    num5_next[k] = cof4_reg[k];
                end
            end
            default:
            begin
                det5_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det5_reg <= det5_next;
            ok5_reg  <= (ord4_reg == ORDER_2) || (ord4_reg == ORDER_3);
            ord5_reg <= ord4_reg;
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                num5_reg[k] <= num5_next[k];
            end
        end
    end

    // stage 6: magnitudes and signs
    always_comb
    begin
        det_zero            = (det5_reg == '0);
        side6_next.singular = ok5_reg && det_zero;
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            nmag_next[k]       = num5_reg[k][CW-1] ? CW'(-num5_reg[k]) : CW'(num5_reg[k]);
            side6_next.neg[k]  = num5_reg[k][CW-1] ^ det5_reg[DW-1];
            side6_next.kill[k] = !ok5_reg || det_zero
                                 || ((ord5_reg == ORDER_2) && !ORDER2_USED[k]);
        end
    end

    // sideband runs beside the divider inputs, then beside its entry stage and each quotient bit stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmag6_reg <= det5_reg[DW-1] ? DW'(-det5_reg) : DW'(det5_reg);
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                nmag6_reg[k] <= nmag_next[k];
            end
            side_reg[0] <= side6_next;
            for (int i = 1; i <= W + 1; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar g = 0; g < NUM_ELEMS; g++)
    begin : g_div
        smi_div #(
            .QW  (W),
            .NW  (NW),
            .DVW (DW)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num ({nmag6_reg[g], {(2*FRAC_BITS){1'b0}}}),
            .den (dmag6_reg),
            .quo (quo[g]),
            .ovf (ovf[g])
        );
    end

    // saturate to the signed output range
    always_comb
    begin
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            if (side_reg[W+1].kill[k])
            begin
                inv_next[k] = '0;
            end
            else if (side_reg[W+1].neg[k])
            begin
                if (ovf[k] || (quo[k][W-1] && (quo[k][W-2:0] != '0)))
                begin
                    inv_next[k] = {1'b1, {(W-1){1'b0}}};
                end
                else
                begin
                    inv_next[k] = -$signed(quo[k]);
                end
            end
            else
            begin
                if (ovf[k] || quo[k][W-1])
                begin
                    inv_next[k] = {1'b0, {(W-1){1'b1}}};
                end
                else
                begin
                    inv_next[k] = $signed(quo[k]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            singular_reg <= side_reg[W+1].singular;
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                inv_reg[k] <= inv_next[k];
            end
        end
    end

    assign inv_valid = vld_reg[LAT-1];
    assign singular  = singular_reg;
    assign inv_r0c0  = inv_reg[0];
    assign inv_r0c1  = inv_reg[1];
    assign inv_r0c2  = inv_reg[2];
    assign inv_r1c0  = inv_reg[3];
    assign inv_r1c1  = inv_reg[4];
    assign inv_r1c2  = inv_reg[5];
    assign inv_r2c0  = inv_reg[6];
    assign inv_r2c1  = inv_reg[7];
    assign inv_r2c2  = inv_reg[8];

`ifndef ASSERT_OFF
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && singular |-> (inv_r0c0 == '0) && (inv_r0c1 == '0) && (inv_r0c2 == '0)
            && (inv_r1c0 == '0) && (inv_r1c1 == '0) && (inv_r1c2 == '0)
            && (inv_r2c0 == '0) && (inv_r2c1 == '0) && (inv_r2c2 == '0))
        else $error("singular result with nonzero elements");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> inv_valid && inv_stall)
        else $error("input stalled without a blocked result");

    a_transfer_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_stall |=> inv_valid && $stable(singular) && $stable(inv_r1c1))
        else $error("blocked result lost or changed");
`endif

endmodule

`default_nettype wire

@@ rtl/smi_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Produces QW quotient bits plus an overflow flag when the quotient needs more.
// No dependencies.
`default_nettype none

module smi_div #(
    parameter int QW  = 32,
    parameter int NW  = 97,
    parameter int DVW = 99
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [NW-1:0]  num,
    input  wire logic [DVW-1:0] den,
    output logic      [QW-1:0]  quo,
    output logic                ovf
);

    localparam int HW = NW - QW;
    localparam int MW = ((HW > DVW) ? HW : DVW) + 1;

    logic [DVW-1:0] rem_reg  [QW+1];
    logic [DVW-1:0] rem_next [QW+1];
    logic [QW-1:0]  low_reg  [QW+1];
    logic [QW-1:0]  low_next [QW+1];
    logic [QW-1:0]  quo_reg  [QW+1];
    logic [QW-1:0]  quo_next [QW+1];
    logic [DVW-1:0] den_reg  [QW+1];
    logic [DVW-1:0] den_next [QW+1];
    logic           ovf_reg  [QW+1];
    logic           ovf_next [QW+1];

    logic [MW-1:0]  hi_ext;
    logic [DVW:0]   trial [QW+1];
    logic [DVW:0]   diff  [QW+1];
    logic           ge    [QW+1];

    always_comb
    begin
        // entry: upper part of the dividend seeds the remainder
        hi_ext      = MW'(num[NW-1:QW]);
        ovf_next[0] = (hi_ext >= MW'(den));
        rem_next[0] = hi_ext[DVW-1:0];
        low_next[0] = num[QW-1:0];
        quo_next[0] = '0;
        den_next[0] = den;
        trial[0]    = '0;
        diff[0]     = '0;
        ge[0]       = 1'b0;
        for (int i = 1; i <= QW; i++)
        begin
            trial[i]    = {rem_reg[i-1], low_reg[i-1][QW-1]};
            diff[i]     = trial[i] - {1'b0, den_reg[i-1]};
            ge[i]       = (trial[i] >= {1'b0, den_reg[i-1]});
            rem_next[i] = ge[i] ? diff[i][DVW-1:0] : trial[i][DVW-1:0];
            low_next[i] = low_reg[i-1] << 1;
            quo_next[i] = {quo_reg[i-1][QW-2:0], ge[i]};
            den_next[i] = den_reg[i-1];
            ovf_next[i] = ovf_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QW; i++)
            begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_next[i];
                ovf_reg[i] <= ovf_next[i];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

`default_nettype wire
